// ----- rtl/glr_pkg.sv -----
`timescale 1ns / 1ps

package glr_pkg;

    // Operation codes carried on the slave tuser
    localparam logic [1:0] OP_RENDER    = 2'd0;
    localparam logic [1:0] OP_WR_RANGE  = 2'd1;
    localparam logic [1:0] OP_WR_WIDTH  = 2'd2;
    localparam logic [1:0] OP_WR_ROW    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FONT_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_TOP_BIT     = 2'd1;
    localparam logic [1:0] CFG_INDEX_COUNT = 2'd2;

    // Field widths
    localparam int CP_W    = 21;
    localparam int SLOT_W  = 6;
    localparam int GNUM_W  = 8;
    localparam int ROW_W   = 5;
    localparam int BITS_W  = 32;
    localparam int WIDTH_W = 6;
    localparam int HGT_W   = 6;
    localparam int TOP_W   = 5;
    localparam int CNT_IN_W = 7;
    localparam int GSUM_W  = 22;

    // One range table entry
    typedef struct packed {
        logic [GNUM_W-1:0] base;
        logic [CP_W-1:0]   last;
        logic [CP_W-1:0]   first;
    } glr_range_ent_t;

    // Range table write
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        glr_range_ent_t    ent;
    } glr_range_wr_t;

    // Search request and answer
    typedef struct packed {
        logic            start;
        logic [CP_W-1:0] key;
    } glr_srch_req_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [GSUM_W-1:0] glyph;
    } glr_srch_res_t;

    // Glyph store write
    typedef struct packed {
        logic               width_en;
        logic               row_en;
        logic [GNUM_W-1:0]  glyph;
        logic [ROW_W-1:0]   row;
        logic [BITS_W-1:0]  bits;
        logic [WIDTH_W-1:0] width;
    } glr_glyph_wr_t;

    // Mirror a row word into pixel order, masked to the glyph width
    function automatic logic [BITS_W-1:0] render_row(input logic [BITS_W-1:0]  bits,
                                                     input logic [TOP_W-1:0]   top,
                                                     input logic [WIDTH_W-1:0] w);
        logic [BITS_W-1:0] px;
        px = '0;
        for (int x = 0; x < BITS_W; x++)
        begin
            if ((TOP_W'(x) <= top) && (WIDTH_W'(x) < w))
            begin
                px[x] = bits[top - TOP_W'(x)];
            end
        end
        return px;
    endfunction

endpackage

// ----- rtl/glr_range_search.sv -----
`timescale 1ns / 1ps

module glr_range_search
    import glr_pkg::*;
#(
    parameter int INDEX_DEPTH = 64,
    parameter int GLYPH_DEPTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  glr_range_wr_t       wr,
    input  glr_srch_req_t       req,
    input  logic [CNT_IN_W-1:0] count,
    output glr_srch_res_t       res
);

    localparam int IDX_W = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int CNT_W = $clog2(INDEX_DEPTH + 1);

    localparam logic [1:0] SR_IDLE  = 2'd0;
    localparam logic [1:0] SR_PROBE = 2'd1;
    localparam logic [1:0] SR_CMP   = 2'd2;
    localparam logic [1:0] SR_FIN   = 2'd3;

    glr_range_ent_t mem [INDEX_DEPTH];
    glr_range_ent_t rd_q;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [CP_W-1:0]  key_reg, key_next;
    glr_srch_res_t    res_reg, res_next;

    logic [CNT_W-1:0]  probe;
    logic [GSUM_W-1:0] gsum;

    assign probe = lo_reg + (n_reg >> 1);
    assign gsum  = GSUM_W'(rd_q.base) + GSUM_W'(key_reg - rd_q.first);

    // Range table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en && (32'(wr.slot) < INDEX_DEPTH))
        begin
            mem[IDX_W'(wr.slot)] <= wr.ent;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    // Halving lower-bound walk: each probe reads the table in SR_PROBE, then compares in SR_CMP
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        n_next     = n_reg;
        lim_next   = lim_reg;
        probe_next = probe_reg;
        key_next   = key_reg;
        res_next   = '0;
        rd_en      = 1'b0;
        rd_addr    = IDX_W'(probe);
        case (state_reg)
            SR_IDLE:
            begin
                if (req.start)
                begin
                    key_next = req.key;
                    lo_next  = '0;
                    if (32'(count) > INDEX_DEPTH)
                    begin
                        lim_next = CNT_W'(INDEX_DEPTH);
                    end
                    else
                    begin
                        lim_next = CNT_W'(count);
                    end
                    n_next     = lim_next;
                    state_next = SR_PROBE;
                end
            end
            SR_PROBE:
            begin
                if (n_reg != '0)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(probe);
                    probe_next = IDX_W'(probe);
                    state_next = SR_CMP;
                end
                else if (lo_reg < lim_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(lo_reg);
                    state_next = SR_FIN;
                end
                else
                begin
                    res_next.done = 1'b1;
                    state_next    = SR_IDLE;
                end
            end
            SR_CMP:
            begin
                if (rd_q.last < key_reg)
                begin
                    lo_next = CNT_W'(probe_reg) + CNT_W'(1);
                    n_next  = n_reg - (n_reg >> 1) - CNT_W'(1);
                end
                else
                begin
                    n_next = n_reg >> 1;
                end
                state_next = SR_PROBE;
            end
            SR_FIN:
            begin
                res_next.done  = 1'b1;
                res_next.glyph = gsum;
                res_next.hit   = (key_reg >= rd_q.first) && (key_reg <= rd_q.last)
                                 && (32'(gsum) < GLYPH_DEPTH);
                state_next     = SR_IDLE;
            end
            default:
            begin
                state_next = SR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SR_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        n_reg     <= n_next;
        lim_reg   <= lim_next;
        probe_reg <= probe_next;
        key_reg   <= key_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/glr_glyph_store.sv -----
`timescale 1ns / 1ps

module glr_glyph_store
    import glr_pkg::*;
#(
    parameter int GLYPH_DEPTH = 256,
    parameter int MAX_ROWS    = 32,
    localparam int GW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
)
(
    input  logic               clk,
    input  glr_glyph_wr_t      wr,
    input  logic [GW-1:0]      rd_glyph,
    input  logic               width_rd_en,
    input  logic               row_rd_en,
    input  logic [RW-1:0]      rd_row,
    output logic [WIDTH_W-1:0] width_q,
    output logic [BITS_W-1:0]  row_q
);

    localparam int ROW_DEPTH = GLYPH_DEPTH << RW;

    logic [WIDTH_W-1:0] width_mem [GLYPH_DEPTH];
    logic [BITS_W-1:0]  row_mem   [ROW_DEPTH];

    logic glyph_ok;
    assign glyph_ok = (32'(wr.glyph) < GLYPH_DEPTH);

    // Width store
    always_ff @(posedge clk)
    begin
        if (wr.width_en && glyph_ok)
        begin
            width_mem[GW'(wr.glyph)] <= wr.width;
        end
        if (width_rd_en)
        begin
            width_q <= width_mem[rd_glyph];
        end
    end

    // Row store, addressed by glyph and row
    always_ff @(posedge clk)
    begin
        if (wr.row_en && glyph_ok && (32'(wr.row) < MAX_ROWS))
        begin
            row_mem[{GW'(wr.glyph), RW'(wr.row)}] <= wr.bits;
        end
        if (row_rd_en)
        begin
            row_q <= row_mem[{rd_glyph, rd_row}];
        end
    end

endmodule

// ----- rtl/glyph_lookup_row_render.sv -----
`timescale 1ns / 1ps

// Bitmap font glyph lookup and row renderer. Write transactions (tuser 1, 2, 3) load the
// range table, the glyph widths and the glyph rows and return nothing; the block stays
// ready after each. A render transaction (tuser 0) walks the sorted range table by binary
// search, each probe a read and then a compare on the range memory, then reads one glyph
// row per cycle from the row memory while the sink accepts and returns font_height results
// (clamped to 1..MAX_ROWS), the last with tlast; a code point without a glyph returns one
// result with tuser low. The render time is set by the single read port of each memory
// and by the output register, which stalls the row reads while the sink holds tready low.
// The next transaction is taken once the final result sits in the output register.
// The stores hold unknown data after reset until written.

module glyph_lookup_row_render
    import glr_pkg::*;
#(
    parameter int INDEX_DEPTH = 64,
    parameter int GLYPH_DEPTH = 256,
    parameter int MAX_ROWS    = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // code_point[20:0], entry_slot[26:21], range_last[47:27], glyph_number[55:48],
    // row_number[60:56], row_bits[92:61], new_width[98:93], zero pad
    input  logic [103:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // out_row[4:0], row_pixels[36:5], advance_width[42:37], zero pad
    output logic [47:0]  m_axis_tdata,
    // found[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int GW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_WIDTH  = 3'd2;
    localparam logic [2:0] ST_ROWS   = 3'd3;
    localparam logic [2:0] ST_MISS   = 3'd4;

    // Input field split
    logic [CP_W-1:0]    in_cp;
    logic [SLOT_W-1:0]  in_slot;
    logic [CP_W-1:0]    in_last;
    logic [GNUM_W-1:0]  in_glyph;
    logic [ROW_W-1:0]   in_row;
    logic [BITS_W-1:0]  in_bits;
    logic [WIDTH_W-1:0] in_width;

    assign in_cp    = s_axis_tdata[20:0];
    assign in_slot  = s_axis_tdata[26:21];
    assign in_last  = s_axis_tdata[47:27];
    assign in_glyph = s_axis_tdata[55:48];
    assign in_row   = s_axis_tdata[60:56];
    assign in_bits  = s_axis_tdata[92:61];
    assign in_width = s_axis_tdata[98:93];

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    logic [HGT_W-1:0]    font_height_reg;
    logic [TOP_W-1:0]    top_bit_reg;
    logic [CNT_IN_W-1:0] index_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_height_reg <= HGT_W'(8);
            top_bit_reg     <= TOP_W'(7);
            index_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FONT_HEIGHT: font_height_reg <= cfg_data[HGT_W-1:0];
                CFG_TOP_BIT:     top_bit_reg     <= cfg_data[TOP_W-1:0];
                CFG_INDEX_COUNT: index_count_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Store writes and search request
    glr_range_wr_t range_wr;
    glr_glyph_wr_t glyph_wr;
    glr_srch_req_t srch_req;
    glr_srch_res_t srch_res;

    assign range_wr.en         = in_acc && (s_axis_tuser == OP_WR_RANGE);
    assign range_wr.slot       = in_slot;
    assign range_wr.ent.first  = in_cp;
    assign range_wr.ent.last   = in_last;
    assign range_wr.ent.base   = in_glyph;

    assign glyph_wr.width_en = in_acc && (s_axis_tuser == OP_WR_WIDTH);
    assign glyph_wr.row_en   = in_acc && (s_axis_tuser == OP_WR_ROW);
    assign glyph_wr.glyph    = in_glyph;
    assign glyph_wr.row      = in_row;
    assign glyph_wr.bits     = in_bits;
    assign glyph_wr.width    = in_width;

    assign srch_req.start = in_acc && (s_axis_tuser == OP_RENDER);
    assign srch_req.key   = in_cp;

    glr_range_search #(
        .INDEX_DEPTH (INDEX_DEPTH),
        .GLYPH_DEPTH (GLYPH_DEPTH)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (range_wr),
        .req   (srch_req),
        .count (index_count_reg),
        .res   (srch_res)
    );

    logic [GW-1:0]      glyph_reg, glyph_next;
    logic               width_rd_en;
    logic               row_rd_en;
    logic [WIDTH_W-1:0] width_q;
    logic [BITS_W-1:0]  row_q;
    logic [HGT_W-1:0]   iss_reg, iss_next;

    glr_glyph_store #(
        .GLYPH_DEPTH (GLYPH_DEPTH),
        .MAX_ROWS    (MAX_ROWS)
    ) u_store (
        .clk         (clk),
        .wr          (glyph_wr),
        .rd_glyph    (glyph_reg),
        .width_rd_en (width_rd_en),
        .row_rd_en   (row_rd_en),
        .rd_row      (RW'(iss_reg)),
        .width_q     (width_q),
        .row_q       (row_q)
    );

    // Render control
    logic [2:0]       state_reg, state_next;
    logic [HGT_W-1:0] h_reg, h_next;
    logic             pend_reg, pend_next;
    logic [ROW_W-1:0] rd_row_reg, rd_row_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [BITS_W-1:0]  out_pix_reg, out_pix_next;
    logic [WIDTH_W-1:0] out_width_reg, out_width_next;
    logic               out_last_reg, out_last_next;

    logic load_ok;
    logic move;
    logic issue;
    logic row_last;

    assign load_ok  = !out_valid_reg || m_axis_tready;
    assign move     = (state_reg == ST_ROWS) && pend_reg && load_ok;
    assign issue    = (state_reg == ST_ROWS) && (iss_reg < h_reg) && (!pend_reg || load_ok);
    assign row_last = ((HGT_W'(rd_row_reg) + HGT_W'(1)) == h_reg);

    always_comb
    begin
        state_next     = state_reg;
        glyph_next     = glyph_reg;
        h_next         = h_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        rd_row_next    = rd_row_reg;
        width_rd_en    = 1'b0;
        row_rd_en      = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_found_next = out_found_reg;
        out_row_next   = out_row_reg;
        out_pix_next   = out_pix_reg;
        out_width_next = out_width_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (srch_req.start)
                begin
                    // clamp the row count into 1..MAX_ROWS
                    if (font_height_reg == '0)
                    begin
                        h_next = HGT_W'(1);
                    end
                    else if (32'(font_height_reg) > MAX_ROWS)
                    begin
                        h_next = HGT_W'(MAX_ROWS);
                    end
                    else
                    begin
                        h_next = font_height_reg;
                    end
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (srch_res.done)
                begin
                    glyph_next = GW'(srch_res.glyph);
                    state_next = srch_res.hit ? ST_WIDTH : ST_MISS;
                end
            end
            ST_WIDTH:
            begin
                width_rd_en = 1'b1;
                iss_next    = '0;
                pend_next   = 1'b0;
                state_next  = ST_ROWS;
            end
            ST_ROWS:
            begin
                // hand the fetched row to the output register
                if (move)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_row_next   = rd_row_reg;
                    out_pix_next   = render_row(row_q, top_bit_reg, width_q);
                    out_width_next = width_q;
                    out_last_next  = row_last;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                // fetch the next row while the read register drains
                if (issue)
                begin
                    row_rd_en   = 1'b1;
                    rd_row_next = ROW_W'(iss_reg);
                    iss_next    = iss_reg + HGT_W'(1);
                end
                pend_next = issue || (pend_reg && !move);
            end
            ST_MISS:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_row_next   = '0;
                    out_pix_next   = '0;
                    out_width_next = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg     <= glyph_next;
        h_reg         <= h_next;
        iss_reg       <= iss_next;
        rd_row_reg    <= rd_row_next;
        out_found_reg <= out_found_next;
        out_row_reg   <= out_row_next;
        out_pix_reg   <= out_pix_next;
        out_width_reg <= out_width_next;
        out_last_reg  <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_width_reg, out_pix_reg, out_row_reg};

    // A not-found result always closes its render transaction
    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("not-found result without tlast");

    // Search answers arrive only while the controller waits for them
    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_res.done |-> (state_reg == ST_SEARCH))
        else $error("search answer outside search state");

    // A fetched row is pending only during row rendering
    a_pend_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_ROWS))
        else $error("row pending outside row state");

    // A render transaction starts the search on the next cycle
    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RENDER))
        |=> (state_reg == ST_SEARCH))
        else $error("render transaction did not start a search");

endmodule

// ----- tb/glyph_lookup_row_render_tb.sv -----
`timescale 1ns / 1ps

module glyph_lookup_row_render_tb;
    import glr_pkg::*;

    localparam int SLOTS        = 64;
    localparam int GLYPHS       = 256;
    localparam int ROWS         = 32;
    localparam int CP_MAX       = 1114111;
    localparam int BAND         = 17476;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_OFF     = 400;
    localparam int PHASE_ITEMS  = 31;
    // Every range base sits in the top glyphs, so a hit can only land on them
    localparam int POOL_BASE    = 252;
    localparam int POOL         = 4;

    // One input transaction, one field per item field
    typedef struct packed {
        logic [1:0]  op;
        logic [20:0] cp;
        logic [5:0]  slot;
        logic [20:0] rlast;
        logic [7:0]  gnum;
        logic [4:0]  rnum;
        logic [31:0] rbits;
        logic [5:0]  width;
    } glyph_cmd_t;

    // One rendered row as it leaves the block
    typedef struct packed {
        logic        found;
        logic [4:0]  row;
        logic [31:0] pixels;
        logic [5:0]  advance;
        logic        last;
    } glyph_row_t;

    // Directed table entry: a register write or a transaction, optionally with its row typed in
    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [6:0]  reg_val;
        bit          typed;
        glyph_cmd_t  cmd;
        glyph_row_t  want;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [103:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [6:0]   cfg_data = '0;

    // Font copy kept by the bench
    logic [20:0]  pr_first [SLOTS];
    logic [20:0]  pr_last  [SLOTS];
    logic [7:0]   pr_base  [SLOTS];
    logic [5:0]   pr_width [GLYPHS];
    logic [31:0]  pr_rows  [GLYPHS*ROWS];
    logic [5:0]   m_rows = 6'd8;
    logic [4:0]   m_top = 5'd7;
    logic [6:0]   m_count = 7'd0;

    glyph_row_t   pending_rows[$];
    int           err_count = 0;
    int           result_count = 0;
    bit           calm = 1'b0;

    glyph_lookup_row_render dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Lower-bound walk over the range table; returns 1 on a hit with the glyph number
    function automatic bit search_table(input logic [20:0] cp, output logic [7:0] g);
        int lim;
        int lo;
        int n;
        int half;
        int probe;
        int sum;
        g = '0;
        lim = (m_count > SLOTS) ? SLOTS : int'(m_count);
        lo = 0;
        n = lim;
        while (n > 0)
        begin
            half = n / 2;
            probe = lo + half;
            if (pr_last[probe] < cp)
            begin
                lo = probe + 1;
                n -= half + 1;
            end
            else
            begin
                n = half;
            end
        end
        if (lo >= lim)
            return 1'b0;
        if (cp < pr_first[lo] || cp > pr_last[lo])
            return 1'b0;
        sum = int'(pr_base[lo]) + (int'(cp) - int'(pr_first[lo]));
        if (sum >= GLYPHS)
            return 1'b0;
        g = sum[7:0];
        return 1'b1;
    endfunction

    // Mirror a row word into column order, masked to the glyph width
    function automatic logic [31:0] mirror_row(input logic [31:0] bits, input logic [5:0] w);
        logic [31:0] px;
        px = '0;
        for (int x = 0; x <= int'(m_top); x++)
        begin
            if (x < int'(w) && bits[int'(m_top) - x])
                px[x] = 1'b1;
        end
        return px;
    endfunction

    // Apply one transaction to the font copy; a render queues its rows
    task automatic apply_font_cmd(input glyph_cmd_t c);
        logic [7:0] g;
        logic [5:0] w;
        int h;
        glyph_row_t r;
        case (c.op)
            OP_WR_RANGE:
            begin
                pr_first[c.slot] = c.cp;
                pr_last[c.slot] = c.rlast;
                pr_base[c.slot] = c.gnum;
            end
            OP_WR_WIDTH:
                pr_width[c.gnum] = c.width;
            OP_WR_ROW:
                pr_rows[{c.gnum, c.rnum}] = c.rbits;
            OP_RENDER:
            begin
                if (!search_table(c.cp, g))
                begin
                    r = '0;
                    r.last = 1'b1;
                    pending_rows.push_back(r);
                end
                else
                begin
                    h = int'(m_rows);
                    if (h < 1)
                        h = 1;
                    if (h > ROWS)
                        h = ROWS;
                    w = pr_width[g];
                    for (int y = 0; y < h; y++)
                    begin
                        r.found = 1'b1;
                        r.row = 5'(y);
                        r.pixels = mirror_row(pr_rows[{g, 5'(y)}], w);
                        r.advance = w;
                        r.last = (y == h - 1);
                        pending_rows.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offer one transaction, wait for acceptance, then record what it must cause
    task automatic send_cmd(input glyph_cmd_t c, input bit typed, input glyph_row_t want);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {5'd0, c.width, c.rbits, c.rnum, c.gnum, c.rlast, c.slot, c.cp};
        s_axis_tuser <= c.op;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
            pending_rows.push_back(want);
        else
            apply_font_cmd(c);
    endtask

    // Stop offering and let every outstanding row drain, plus the block's latency
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register once the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FONT_HEIGHT: m_rows = val[5:0];
            CFG_TOP_BIT:     m_top = val[4:0];
            CFG_INDEX_COUNT: m_count = val;
            default: ;
        endcase
    endtask

    function automatic glyph_cmd_t rand_fields();
        glyph_cmd_t c;
        c.op = OP_RENDER;
        c.cp = 21'($urandom_range(0, CP_MAX));
        c.slot = 6'($urandom_range(0, SLOTS - 1));
        c.rlast = 21'($urandom_range(0, CP_MAX));
        c.gnum = 8'(POOL_BASE + $urandom_range(0, POOL - 1));
        c.rnum = 5'($urandom_range(0, ROWS - 1));
        c.rbits = $urandom;
        c.width = 6'($urandom_range(0, 32));
        return c;
    endfunction

    function automatic stim_row_t stim_cfg(input logic [1:0] idx, input logic [6:0] val);
        stim_row_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic stim_row_t stim_item(input logic [1:0] op, input logic [20:0] cp,
                                            input logic [5:0] slot, input logic [20:0] rlast,
                                            input logic [7:0] gnum, input logic [4:0] rnum,
                                            input logic [31:0] rbits, input logic [5:0] width);
        stim_row_t s;
        s = '0;
        s.cmd = '{op, cp, slot, rlast, gnum, rnum, rbits, width};
        return s;
    endfunction

    function automatic stim_row_t stim_typed(input logic [20:0] cp, input logic found,
                                             input logic [4:0] row, input logic [31:0] px,
                                             input logic [5:0] adv, input logic last);
        stim_row_t s;
        s = stim_item(OP_RENDER, cp, '0, '0, '0, '0, '0, '0);
        s.typed = 1'b1;
        s.want = '{found, row, px, adv, last};
        return s;
    endfunction

    // Random transaction: mostly renders aimed at live ranges, the rest writes and noise
    task automatic random_cmd(output glyph_cmd_t c);
        int pick;
        int lim;
        int s;
        int span;
        int lo_b;
        int hi_b;
        int f;
        c = rand_fields();
        pick = $urandom_range(0, 99);
        lim = (m_count > SLOTS) ? SLOTS : int'(m_count);
        if (pick < 62)
        begin
            if (lim > 0)
            begin
                s = $urandom_range(0, lim - 1);
                span = int'(pr_last[s]) - int'(pr_first[s]);
                if (span < 0)
                    span = 0;
                // mostly near the range start, where the glyph stays in the store
                if ($urandom_range(0, 5) == 0)
                    c.cp = pr_last[s];
                else if ($urandom_range(0, 3) == 0)
                    c.cp = 21'(int'(pr_first[s]) + $urandom_range(0, (span > 300) ? 300 : span));
                else
                    c.cp = 21'(int'(pr_first[s])
                               + $urandom_range(0, (span < POOL) ? span : POOL - 1));
            end
        end
        else if (pick < 72)
        begin
            c.op = OP_RENDER;
        end
        else if (pick < 82)
        begin
            c.op = OP_WR_ROW;
            if ($urandom_range(0, 7) == 0)
                c.rbits = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        end
        else if (pick < 90)
        begin
            c.op = OP_WR_WIDTH;
        end
        else
        begin
            c.op = OP_WR_RANGE;
            s = c.slot;
            lo_b = (s == 0) ? 0 : int'(pr_last[s - 1]) + 1;
            hi_b = (s == SLOTS - 1) ? CP_MAX : int'(pr_first[s + 1]) - 1;
            // keep the table sorted most of the time; otherwise leave the random range
            if ($urandom_range(0, 2) != 0 && lo_b <= hi_b)
            begin
                f = $urandom_range(lo_b, hi_b);
                c.cp = 21'(f);
                c.rlast = 21'($urandom_range(f, (hi_b > f + 63) ? f + 63 : hi_b));
            end
        end
    endtask

    // Load the range table and every glyph a range can reach, so no render reads
    // an unwritten entry
    task automatic preload_font();
        glyph_cmd_t c;
        int first;
        for (int s = 0; s < SLOTS; s++)
        begin
            c = rand_fields();
            c.op = OP_WR_RANGE;
            c.slot = 6'(s);
            first = (s == 0) ? $urandom_range(0, 100) : s * BAND + $urandom_range(1, 2000);
            c.cp = 21'(first);
            if ($urandom_range(0, 7) == 0)
                c.rlast = 21'(first + $urandom_range(0, 1000));
            else
                c.rlast = 21'(first + $urandom_range(0, 63));
            send_cmd(c, 1'b0, '0);
        end
        for (int g = 0; g < POOL; g++)
        begin
            c = rand_fields();
            c.op = OP_WR_WIDTH;
            c.gnum = 8'(POOL_BASE + g);
            send_cmd(c, 1'b0, '0);
        end
        for (int g = 0; g < POOL; g++)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                c = rand_fields();
                c.op = OP_WR_ROW;
                c.gnum = 8'(POOL_BASE + g);
                c.rnum = 5'(r);
                if ($urandom_range(0, 15) == 0)
                    c.rbits = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                send_cmd(c, 1'b0, '0);
            end
        end
    endtask

    // Compare each accepted result with the oldest queued row
    always @(posedge clk)
    begin : check_results
        glyph_row_t want;
        glyph_row_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            got = '{m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[36:5],
                    m_axis_tdata[42:37], m_axis_tlast};
            if (pending_rows.size() == 0)
            begin
                $error("result with nothing queued: found %0d row %0d", got.found, got.row);
                err_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    err_count++;
                end
                if (got.row !== want.row)
                begin
                    $error("out_row: expected %0d, got %0d", want.row, got.row);
                    err_count++;
                end
                if (got.pixels !== want.pixels)
                begin
                    $error("row_pixels: expected %h, got %h", want.pixels, got.pixels);
                    err_count++;
                end
                if (got.advance !== want.advance)
                begin
                    $error("advance_width: expected %0d, got %0d", want.advance, got.advance);
                    err_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_row: expected %0d, got %0d", want.last, got.last);
                    err_count++;
                end
            end
        end
    end

    // Sink: bursts of ready with random stalls, and one long hold-off while input is offered
    initial
    begin : result_sink
        int run;
        int stall;
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                run = $urandom_range(100, 200);
            else
                run = $urandom_range(1, 40);
            repeat (run) @(posedge clk);
            if (!held && result_count >= 300 && s_axis_tvalid)
            begin
                held = 1'b1;
                stall = HOLD_OFF;
            end
            else
            begin
                stall = pick_gap(1'b0);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t  directed_rows[$];
        glyph_cmd_t c;
        int         phase_h[8];
        int         phase_t[8];
        int         phase_c[8];

        phase_h = '{8, 32, 1, 16, 5, 63, 0, 12};
        phase_t = '{7, 31, 0, 15, 31, 9, 20, 11};
        phase_c = '{64, 64, 64, 40, 1, 127, 0, 64};

        // Reset after-values: empty range table, so every render misses
        directed_rows.push_back(stim_typed(21'd0, 1'b0, 5'd0, 32'h0, 6'd0, 1'b1));
        directed_rows.push_back(stim_typed(21'h10FFFF, 1'b0, 5'd0, 32'h0, 6'd0, 1'b1));
        directed_rows.push_back(stim_cfg(CFG_INDEX_COUNT, 7'd64));
        // Extreme ranges at both ends of the table and extreme glyph contents
        directed_rows.push_back(stim_item(OP_WR_RANGE, 21'd0, 6'd0, 21'd3, 8'd252, '0, '0, '0));
        directed_rows.push_back(stim_item(OP_WR_RANGE, 21'h10FFF0, 6'd63, 21'h10FFFF, 8'd255,
                                          '0, '0, '0));
        directed_rows.push_back(stim_item(OP_WR_WIDTH, '0, '0, '0, 8'd252, '0, '0, 6'd32));
        directed_rows.push_back(stim_item(OP_WR_WIDTH, '0, '0, '0, 8'd255, '0, '0, 6'd0));
        directed_rows.push_back(stim_item(OP_WR_ROW, '0, '0, '0, 8'd252, 5'd0, 32'hFFFF_FFFF,
                                          '0));
        directed_rows.push_back(stim_item(OP_WR_ROW, '0, '0, '0, 8'd252, 5'd31, 32'h0, '0));
        directed_rows.push_back(stim_item(OP_WR_ROW, '0, '0, '0, 8'd255, 5'd0, 32'hFFFF_FFFF,
                                          '0));
        // Wide glyph, zero-width glyph, glyph past the store, code point in a gap
        directed_rows.push_back(stim_item(OP_RENDER, 21'd0, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(stim_item(OP_RENDER, 21'h10FFF0, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(stim_typed(21'h10FFFF, 1'b0, 5'd0, 32'h0, 6'd0, 1'b1));
        directed_rows.push_back(stim_typed(21'd4, 1'b0, 5'd0, 32'h0, 6'd0, 1'b1));
        // Full height and widest rows
        directed_rows.push_back(stim_cfg(CFG_FONT_HEIGHT, 7'd32));
        directed_rows.push_back(stim_cfg(CFG_TOP_BIT, 7'd31));
        directed_rows.push_back(stim_item(OP_RENDER, 21'd0, '0, '0, '0, '0, '0, '0));
        // Zero height acts as a single row
        directed_rows.push_back(stim_cfg(CFG_FONT_HEIGHT, 7'd0));
        directed_rows.push_back(stim_typed(21'd0, 1'b1, 5'd0, 32'hFFFF_FFFF, 6'd32, 1'b1));
        directed_rows.push_back(stim_cfg(CFG_TOP_BIT, 7'd0));
        directed_rows.push_back(stim_typed(21'd0, 1'b1, 5'd0, 32'h1, 6'd32, 1'b1));
        // Oversized height and count saturate
        directed_rows.push_back(stim_cfg(CFG_FONT_HEIGHT, 7'd63));
        directed_rows.push_back(stim_cfg(CFG_INDEX_COUNT, 7'd127));
        directed_rows.push_back(stim_item(OP_RENDER, 21'd1, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(stim_item(OP_RENDER, 21'd3, '0, '0, '0, '0, '0, '0));

        // Hold reset, then release at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        preload_font();

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_FONT_HEIGHT, 7'(phase_h[p]));
            write_reg(CFG_TOP_BIT, 7'(phase_t[p]));
            write_reg(CFG_INDEX_COUNT, 7'(phase_c[p]));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                random_cmd(c);
                send_cmd(c, 1'b0, '0);
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
